// File: src/skqt_pkg.sv
// types, codes and controller/datapath signal groups for the sorted key/quantity table
// no dependencies
`default_nettype none

package skqt_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_DUP     = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] key;
		logic signed [31:0] amount;
	} skqt_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] quantity;
	} skqt_rsp_t;

	typedef enum logic [1:0] {
		QS_ZERO,
		QS_READ,
		QS_AMOUNT,
		QS_SUM
	} skqt_qsel_t;

	typedef struct packed {
		logic       load;
		logic       scan_step;
		logic       pos_load;
		logic       shift_start;
		logic       shift_step;
		logic       ins_write;
		logic       upd_write;
		logic       res_set;
		logic [1:0] res_status;
		skqt_qsel_t res_sel;
		logic       out_load;
	} skqt_ctl_t;

	typedef struct packed {
		logic [1:0] command;
		logic       full;
		logic       scan_hit;
		logic       found;
		logic       no_shift;
		logic       shift_last;
		logic       out_free;
	} skqt_sts_t;

endpackage

`default_nettype wire

// File: src/skqt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module skqt_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 128,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/skqt_datapath.sv
// datapath: key and quantity rams, scan/shift index, entry count, result registers
// depends on skqt_pkg and skqt_ram
`default_nettype none

module skqt_datapath
	import skqt_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire skqt_req_t req,
	input  wire skqt_ctl_t ctl,
	output skqt_sts_t      sts,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output skqt_rsp_t      rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	skqt_req_t          req_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      pos_q;
	logic [1:0]         rs_status_q;
	logic signed [31:0] rs_qty_q;
	logic               rsp_valid_q;
	skqt_rsp_t          rsp_q;

	logic [CW-1:0]      idx_inc;
	logic [CW-1:0]      rd_idx;
	logic [AW-1:0]      rd_addr;
	logic [31:0]        rkey;
	logic [31:0]        rqty;
	logic               key_we;
	logic               qty_we;
	logic [AW-1:0]      key_waddr;
	logic [AW-1:0]      qty_waddr;
	logic [31:0]        key_wdata;
	logic [31:0]        qty_wdata;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_sat;
	logic signed [31:0] res_qty;

	assign idx_inc = idx_q + ONE_C;

	always_comb begin
		if (ctl.load) begin
			rd_idx = '0;
		end else if (ctl.scan_step) begin
			rd_idx = (idx_inc >= DEPTH_C) ? '0 : idx_inc;
		end else if (ctl.shift_start) begin
			rd_idx = count_q - ONE_C;
		end else if (ctl.shift_step) begin
			rd_idx = idx_q - TWO_C;
		end else begin
			rd_idx = idx_q;
		end
	end

	assign rd_addr = rd_idx[AW-1:0];

	assign key_we    = ctl.shift_step | ctl.ins_write;
	assign key_waddr = ctl.shift_step ? idx_q[AW-1:0] : pos_q[AW-1:0];
	assign key_wdata = ctl.shift_step ? rkey : req_q.key;

	assign qty_we    = ctl.shift_step | ctl.ins_write | ctl.upd_write;
	assign qty_waddr = ctl.shift_step ? idx_q[AW-1:0] : pos_q[AW-1:0];
	always_comb begin
		if (ctl.shift_step) begin
			qty_wdata = rqty;
		end else if (ctl.ins_write) begin
			qty_wdata = req_q.amount;
		end else begin
			qty_wdata = rs_qty_q;
		end
	end

	skqt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (rd_addr),
		.rdata (rkey)
	);

	skqt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_qty_ram (
		.clk   (clk),
		.we    (qty_we),
		.waddr (qty_waddr),
		.wdata (qty_wdata),
		.raddr (rd_addr),
		.rdata (rqty)
	);

	// saturating add of the stored quantity and the change
	assign sum_wide = {rqty[31], rqty} + {req_q.amount[31], req_q.amount};
	always_comb begin
		if (sum_wide[32] != sum_wide[31]) begin
			sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sum_sat = sum_wide[31:0];
		end
	end

	always_comb begin
		case (ctl.res_sel)
			QS_READ:   res_qty = rqty;
			QS_AMOUNT: res_qty = req_q.amount;
			QS_SUM:    res_qty = sum_sat;
			default:   res_qty = '0;
		endcase
	end

	assign sts.command    = req_q.command;
	assign sts.full       = (count_q == DEPTH_C);
	assign sts.scan_hit   = (idx_q == count_q) || ($signed(rkey) >= req_q.key);
	assign sts.found      = (idx_q != count_q) && ($signed(rkey) == req_q.key);
	assign sts.no_shift   = (idx_q == count_q);
	assign sts.shift_last = ((idx_q - ONE_C) == pos_q);
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.ins_write) begin
				count_q <= count_q + ONE_C;
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
			idx_q <= '0;
		end else if (ctl.scan_step) begin
			idx_q <= idx_inc;
		end else if (ctl.shift_start) begin
			idx_q <= count_q;
		end else if (ctl.shift_step) begin
			idx_q <= idx_q - ONE_C;
		end
		if (ctl.pos_load) begin
			pos_q <= idx_q;
		end
		if (ctl.res_set) begin
			rs_status_q <= ctl.res_status;
			rs_qty_q    <= res_qty;
		end
		if (ctl.out_load) begin
			rsp_q.status   <= rs_status_q;
			rsp_q.quantity <= rs_qty_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: src/skqt_ctrl.sv
// controller state machine: scan, shift, write-back and result hand-off
// depends on skqt_pkg
`default_nettype none

module skqt_ctrl
	import skqt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire skqt_sts_t sts,
	output skqt_ctl_t      ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_INS_WR,
		S_UPD_WR,
		S_REPORT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		ctl       = '0;
		ctl.res_sel = QS_ZERO;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.scan_hit) begin
					ctl.scan_step = 1'b1;
				end else begin
					ctl.pos_load = 1'b1;
					ctl.res_set  = 1'b1;
					state_nxt    = S_REPORT;
					unique case (sts.command)
						CMD_INSERT: begin
							if (sts.full) begin
								ctl.res_status = ST_FULL;
							end else if (sts.found) begin
								ctl.res_status = ST_DUP;
							end else begin
								ctl.res_set = 1'b0;
								if (sts.no_shift) begin
									state_nxt = S_INS_WR;
								end else begin
									ctl.shift_start = 1'b1;
									state_nxt       = S_SHIFT;
								end
							end
						end
						CMD_SEARCH: begin
							if (sts.found) begin
								ctl.res_status = ST_OK;
								ctl.res_sel    = QS_READ;
							end else begin
								ctl.res_status = ST_MISSING;
							end
						end
						CMD_UPDATE: begin
							if (sts.found) begin
								ctl.res_status = ST_OK;
								ctl.res_sel    = QS_SUM;
								state_nxt      = S_UPD_WR;
							end else begin
								ctl.res_status = ST_MISSING;
							end
						end
						default: begin
							ctl.res_status = ST_MISSING;
						end
					endcase
				end
			end
			S_SHIFT: begin
				ctl.shift_step = 1'b1;
				if (sts.shift_last) begin
					state_nxt = S_INS_WR;
				end
			end
			S_INS_WR: begin
				ctl.ins_write  = 1'b1;
				ctl.res_set    = 1'b1;
				ctl.res_status = ST_OK;
				ctl.res_sel    = QS_AMOUNT;
				state_nxt      = S_REPORT;
			end
			S_UPD_WR: begin
				ctl.upd_write = 1'b1;
				state_nxt     = S_REPORT;
			end
			S_REPORT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/sorted_key_quantity_table.sv
// top level of the sorted key/quantity table: controller plus datapath
// depends on skqt_pkg, skqt_ctrl, skqt_datapath (and skqt_ram below it)
//
// channel   direction  handshake               beat
// req       in         req_valid / req_stall   command, key, amount
// rsp       out        rsp_valid / rsp_stall   status, quantity
//
// one command at a time; the key scan reads one entry a cycle from entry 0
// up to the first key not below the searched one, or to the end of the entries
// an insert then moves one entry a cycle (count - position) and writes the new entry
// an output stall holds the controller in its report state; results leave through an output register
// reset empties the table (entry count zero); no clearing pass, stalled results hold
`default_nettype none

module sorted_key_quantity_table
	import skqt_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire skqt_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output skqt_rsp_t      rsp
);

	skqt_ctl_t ctl;
	skqt_sts_t sts;

	skqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	skqt_datapath #(.DEPTH(DEPTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
